/* rtl/zlbm_pkg.sv */
// ----------------------------------------------------------------------------
// zlbm_pkg
// Shared types and constants of the zone label border marker.
// ----------------------------------------------------------------------------
package zlbm_pkg;

    // Widths fixed by the register and field definitions.
    localparam int CFG_W        = 9;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int LABEL_W      = 3;
    localparam int MASK_W       = 8;
    localparam int MATRIX_W     = 64;
    localparam int ZONE_IDX_W   = 3;
    localparam int HEIGHT_LIMIT = 256;
    localparam int TOTAL_W      = 2 * CFG_W;
    localparam int WIN_SIZE     = 9;
    localparam int WIN_CENTRE   = 4;

    // Result queue.
    localparam int RES_DEPTH    = 4;
    localparam int RES_PTR_W    = 2;
    localparam int RES_CNT_W    = 3;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_MAP_WIDTH  = 2'd0;
    localparam cfg_index_t REG_MAP_HEIGHT = 2'd1;
    localparam cfg_index_t REG_WIDE_PAIRS = 2'd2;

    // Per-tile control computed from the counters when the item is taken.
    typedef struct packed {
        logic                emit;
        logic                last;
        logic                ring;
        logic [WIN_SIZE-1:0] in_map;
        logic [WIN_SIZE-1:0] qualify;
    } tile_ctrl_t;

    typedef struct packed {
        logic              is_border;
        logic [MASK_W-1:0] zone_mask;
        logic              on_edge;
        logic              last;
    } result_t;

    function automatic logic [CFG_W-1:0] clamp_height(input logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] res;
        if (value == '0)
        begin
            res = CFG_W'(1);
        end
        else if (int'(value) > HEIGHT_LIMIT)
        begin
            res = CFG_W'(HEIGHT_LIMIT);
        end
        else
        begin
            res = value;
        end
        return res;
    endfunction

endpackage

/* rtl/zlbm_ram.sv */
// ----------------------------------------------------------------------------
// zlbm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module zlbm_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

/* rtl/zlbm_ctrl.sv */
// ----------------------------------------------------------------------------
// zlbm_ctrl
// Raster counters: input column, fill count, output tile position and tile
// count. Produces the line buffer address and the per-tile edge flags.
// ----------------------------------------------------------------------------
module zlbm_ctrl #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [zlbm_pkg::CFG_W-1:0]     eff_width,
    input  logic [zlbm_pkg::CFG_W-1:0]     eff_height,
    input  logic [zlbm_pkg::TOTAL_W-1:0]   total,
    output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
    output zlbm_pkg::tile_ctrl_t           tile_ctrl
);

    import zlbm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int XW = ((AW > CFG_W) ? AW : CFG_W) + 2;

    logic [AW-1:0]      in_col_reg, in_col_next;
    logic [CFG_W-1:0]   items_reg, items_next;
    logic [CFG_W-1:0]   out_col_reg, out_col_next;
    logic [TOTAL_W-1:0] out_row_reg, out_row_next;
    logic [TOTAL_W-1:0] tiles_reg, tiles_next;

    logic [XW-1:0]      width_x, col_x, inc_x;
    logic [AW-1:0]      col, col_after;
    logic [CFG_W-1:0]   items_after;
    logic               emit, last, col_wrap;
    logic [CFG_W-1:0]   tile_x;
    logic [TOTAL_W-1:0] tile_y, count_after;
    logic [CFG_W:0]     px [3];
    logic [TOTAL_W:0]   py [3];
    logic [2:0]         in_x, in_y, ring_x, ring_y;
    logic               ring;

    always_comb
    begin
        width_x     = XW'(eff_width);
        col_x       = XW'(in_col_reg);
        col         = (col_x >= width_x) ? '0 : in_col_reg;
        inc_x       = XW'(col) + XW'(1);
        col_after   = (inc_x >= width_x) ? '0 : inc_x[AW-1:0];

        // The fill count saturates once it is beyond any possible width.
        items_after = (items_reg == '1) ? items_reg : items_reg + CFG_W'(1);
        emit        = (items_reg >= eff_width);

        col_wrap    = (out_col_reg >= eff_width);
        tile_x      = col_wrap ? '0 : out_col_reg;
        tile_y      = col_wrap ? out_row_reg + TOTAL_W'(1) : out_row_reg;
        count_after = tiles_reg + TOTAL_W'(1);
        last        = (count_after >= total);
    end

    // Neighbour coordinates are kept offset by one so that no value goes
    // negative: p = n + 1 is in the map for 1 <= p <= size.
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            px[d]     = (CFG_W+1)'(tile_x) + (CFG_W+1)'(d);
            py[d]     = (TOTAL_W+1)'(tile_y) + (TOTAL_W+1)'(d);
            in_x[d]   = (px[d] != '0) && (px[d] <= (CFG_W+1)'(eff_width));
            in_y[d]   = (py[d] != '0) && (py[d] <= (TOTAL_W+1)'(eff_height));
            ring_x[d] = (px[d] == (CFG_W+1)'(1)) || (px[d] == (CFG_W+1)'(eff_width));
            ring_y[d] = (py[d] == (TOTAL_W+1)'(1)) || (py[d] == (TOTAL_W+1)'(eff_height));
        end
        ring = ring_x[1] || ring_y[1];

        tile_ctrl.emit    = emit;
        tile_ctrl.last    = last;
        tile_ctrl.ring    = ring;
        tile_ctrl.in_map  = '0;
        tile_ctrl.qualify = '0;
        for (int dy = 0; dy < 3; dy++)
        begin
            for (int dx = 0; dx < 3; dx++)
            begin
                if ((dy * 3 + dx) != WIN_CENTRE)
                begin
                    tile_ctrl.in_map[dy * 3 + dx]  = in_x[dx] && in_y[dy];
                    tile_ctrl.qualify[dy * 3 + dx] = in_x[dx] && in_y[dy]
                        && (!ring || !(ring_x[dx] || ring_y[dy]));
                end
            end
        end
    end

    always_comb
    begin
        in_col_next  = col_after;
        items_next   = items_after;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        tiles_next   = tiles_reg;
        if (emit)
        begin
            if (last)
            begin
                in_col_next  = '0;
                items_next   = '0;
                out_col_next = '0;
                out_row_next = '0;
                tiles_next   = '0;
            end
            else
            begin
                out_col_next = tile_x + CFG_W'(1);
                out_row_next = tile_y;
                tiles_next   = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            items_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            tiles_reg   <= '0;
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            items_reg   <= items_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            tiles_reg   <= tiles_next;
        end
    end

    assign rd_addr = col;

    // The result for the final tile restarts the map from its first tile.
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && last) |=>
            (tiles_reg == '0 && in_col_reg == '0 && items_reg == '0))
        else $error("counters not cleared after the last tile");

endmodule

/* rtl/zlbm_window.sv */
// ----------------------------------------------------------------------------
// zlbm_window
// 3x3 label window and the border evaluation of its centre tile.
// ----------------------------------------------------------------------------
module zlbm_window #(
    parameter int ZONE_BITS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            shift,
    input  zlbm_pkg::tile_ctrl_t            tile_ctrl,
    input  logic [ZONE_BITS-1:0]            col_top,
    input  logic [ZONE_BITS-1:0]            col_mid,
    input  logic [ZONE_BITS-1:0]            col_bottom,
    input  logic [zlbm_pkg::MATRIX_W-1:0]   wide_matrix,
    output logic                            push,
    output zlbm_pkg::result_t               result
);

    import zlbm_pkg::*;

    logic [ZONE_BITS-1:0]  win_reg  [WIN_SIZE];
    logic [ZONE_BITS-1:0]  win_next [WIN_SIZE];
    logic [ZONE_IDX_W-1:0] centre_idx;
    logic [MASK_W-1:0]     wide_row;
    logic [MASK_W-1:0]     zone_mask;
    logic                  any_diff, any_wide;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r * 3]     = win_reg[r * 3 + 1];
            win_next[r * 3 + 1] = win_reg[r * 3 + 2];
        end
        win_next[2] = col_top;
        win_next[5] = col_mid;
        win_next[8] = col_bottom;
    end

    // The new centre is already held in the window, so the wide pairs of the
    // centre zone are looked up in parallel with the line buffer read.
    always_comb
    begin
        centre_idx = ZONE_IDX_W'(win_reg[5]);
        for (int b = 0; b < MASK_W; b++)
        begin
            wide_row[b] = wide_matrix[{centre_idx, ZONE_IDX_W'(b)}]
                        | wide_matrix[{ZONE_IDX_W'(b), centre_idx}];
        end
    end

    always_comb
    begin
        any_diff  = 1'b0;
        any_wide  = 1'b0;
        zone_mask = '0;
        for (int p = 0; p < WIN_SIZE; p++)
        begin
            if (tile_ctrl.in_map[p] && (win_next[p] != win_next[WIN_CENTRE]))
            begin
                any_diff = 1'b1;
                if (wide_row[ZONE_IDX_W'(win_next[p])])
                begin
                    any_wide = 1'b1;
                end
                if (tile_ctrl.qualify[p])
                begin
                    zone_mask[ZONE_IDX_W'(win_next[p])] = 1'b1;
                end
            end
        end

        push             = shift && tile_ctrl.emit;
        result.is_border = any_diff && !any_wide;
        result.zone_mask = zone_mask;
        result.on_edge   = tile_ctrl.ring;
        result.last      = tile_ctrl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < WIN_SIZE; p++)
            begin
                win_reg[p] <= '0;
            end
        end
        else if (shift)
        begin
            for (int p = 0; p < WIN_SIZE; p++)
            begin
                win_reg[p] <= win_next[p];
            end
        end
    end

endmodule

/* rtl/zlbm_res_fifo.sv */
// ----------------------------------------------------------------------------
// zlbm_res_fifo
// Small result queue that decouples the output channel from the pipeline.
// ----------------------------------------------------------------------------
module zlbm_res_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  zlbm_pkg::result_t                 push_data,
    input  logic                              pop,
    output logic                              head_valid,
    output zlbm_pkg::result_t                 head_data,
    output logic [zlbm_pkg::RES_CNT_W-1:0]    count
);

    import zlbm_pkg::*;

    result_t               entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]  count_reg, count_next;
    logic                  do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = push ? wr_ptr_reg + RES_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + RES_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + RES_CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((count_reg != RES_CNT_W'(RES_DEPTH)) || pop))
        else $error("result queue written while full");

endmodule

/* rtl/zone_label_border_marker_unit.sv */
// ----------------------------------------------------------------------------
// zone_label_border_marker_unit
// Zone border marker over a raster stream of tile zone labels.
// ----------------------------------------------------------------------------
// Tiles enter on the tile channel (tile_valid / tile_stall) in raster order,
// one item per cycle unless stalled. Once a map's first map_width+1 items
// are in, every item completes the 3x3 neighbourhood of one earlier tile,
// and its result leaves on the result channel (result_valid / result_stall).
// After the last tile the host sends map_width+1 flush items to drain the
// final results. A result becomes visible once it has passed the s1 stage
// and been written into the result queue. The sustained rate is one item per
// cycle unless stalled; the line buffer is a single RAM read at the item's
// column when the item is taken and written back in the next cycle, with a
// bypass for back-to-back items on one column. After reset the line buffer
// is swept to zero, one entry per cycle, so tile_stall stays high until
// every entry is cleared. A configuration write holds tile_stall high for
// the following cycle while the tile count settles. Results wait in a
// four-entry queue; while the receiver stalls, tile_stall rises once the
// queue and the item in flight would fill it, and nothing is dropped.
// ----------------------------------------------------------------------------
module zone_label_border_marker_unit #(
    parameter int MAX_WIDTH = 256,
    parameter int ZONE_BITS = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_wr_en,
    input  zlbm_pkg::cfg_index_t              cfg_index,
    input  logic [zlbm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                              tile_valid,
    output logic                              tile_stall,
    input  logic [zlbm_pkg::LABEL_W-1:0]      zone_label,
    input  logic                              flush,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              is_border,
    output logic [zlbm_pkg::MASK_W-1:0]       neighbour_zone_mask,
    output logic                              on_map_edge,
    output logic                              last_tile
);

    import zlbm_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int MEM_W = 2 * ZONE_BITS;

    // Configuration.
    logic [CFG_W-1:0]    map_width_reg, map_height_reg;
    logic [MATRIX_W-1:0] wide_matrix_reg;
    logic [CFG_W-1:0]    eff_width_reg, eff_width_next;
    logic [CFG_W-1:0]    eff_height_reg, eff_height_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                cfg_settle_reg;

    // Clearing sweep of the line buffer.
    logic                clearing_reg, clearing_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;

    // Pipeline.
    logic                accept;
    logic [ZONE_BITS-1:0] label_in;
    logic [AW-1:0]       rd_addr;
    tile_ctrl_t          tile_ctrl;
    logic                s1_valid_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [ZONE_BITS-1:0] s1_label_reg;
    tile_ctrl_t          s1_ctrl_reg;

    // Line buffer: each entry holds the label of the previous row and of the
    // current row at one column.
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [MEM_W-1:0]    mem_wr_data, mem_rd_data, col_data;
    logic                fwd_hit_reg;
    logic [MEM_W-1:0]    fwd_data_reg;
    logic [ZONE_BITS-1:0] col_top, col_mid;

    // Results.
    logic                push;
    result_t             push_data, head_data;
    logic [RES_CNT_W-1:0] res_count;
    logic [RES_CNT_W:0]  res_pending;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg   <= CFG_W'(72);
            map_height_reg  <= CFG_W'(72);
            wide_matrix_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg   <= cfg_wr_data[CFG_W-1:0];
                REG_MAP_HEIGHT: map_height_reg  <= cfg_wr_data[CFG_W-1:0];
                REG_WIDE_PAIRS: wide_matrix_reg <= cfg_wr_data[MATRIX_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (map_width_reg == '0)
        begin
            eff_width_next = CFG_W'(1);
        end
        else if (int'(map_width_reg) > MAX_WIDTH)
        begin
            eff_width_next = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width_next = map_width_reg;
        end
        eff_height_next = clamp_height(map_height_reg);
        total_next      = TOTAL_W'(eff_width_next) * TOTAL_W'(eff_height_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_width_reg  <= CFG_W'(72);
            eff_height_reg <= CFG_W'(72);
            total_reg      <= TOTAL_W'(72 * 72);
            cfg_settle_reg <= 1'b0;
        end
        else
        begin
            eff_width_reg  <= eff_width_next;
            eff_height_reg <= eff_height_next;
            total_reg      <= total_next;
            cfg_settle_reg <= cfg_wr_en;
        end
    end

    // ---------------------------------------------------------------- sweep
    always_comb
    begin
        clr_addr_next = clr_addr_reg + AW'(1);
        clearing_next = clearing_reg && (clr_addr_reg != AW'(MAX_WIDTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // ---------------------------------------------------------------- input
    assign res_pending = (RES_CNT_W+1)'(res_count) + (RES_CNT_W+1)'(s1_valid_reg && s1_ctrl_reg.emit);
    assign tile_stall  = clearing_reg || cfg_settle_reg
                      || (res_pending >= (RES_CNT_W+1)'(RES_DEPTH));
    assign accept      = tile_valid && !tile_stall;
    assign label_in    = flush ? '0 : zone_label[ZONE_BITS-1:0];

    zlbm_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .eff_width  (eff_width_reg),
        .eff_height (eff_height_reg),
        .total      (total_reg),
        .rd_addr    (rd_addr),
        .tile_ctrl  (tile_ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= rd_addr;
            s1_label_reg <= label_in;
            s1_ctrl_reg  <= tile_ctrl;
        end
    end

    // ---------------------------------------------------------- line buffer
    always_comb
    begin
        col_data    = fwd_hit_reg ? fwd_data_reg : mem_rd_data;
        col_top     = col_data[MEM_W-1:ZONE_BITS];
        col_mid     = col_data[ZONE_BITS-1:0];
        mem_wr_en   = clearing_reg || s1_valid_reg;
        mem_wr_addr = clearing_reg ? clr_addr_reg : s1_addr_reg;
        mem_wr_data = clearing_reg ? '0 : {col_mid, s1_label_reg};
    end

    zlbm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    // A read that meets a write to the same entry takes the written value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= mem_wr_en && (mem_wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= mem_wr_data;
    end

    // ---------------------------------------------------------------- window
    zlbm_window #(
        .ZONE_BITS (ZONE_BITS)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift       (s1_valid_reg),
        .tile_ctrl   (s1_ctrl_reg),
        .col_top     (col_top),
        .col_mid     (col_mid),
        .col_bottom  (s1_label_reg),
        .wide_matrix (wide_matrix_reg),
        .push        (push),
        .result      (push_data)
    );

    // ---------------------------------------------------------------- output
    zlbm_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (!result_stall),
        .head_valid (result_valid),
        .head_data  (head_data),
        .count      (res_count)
    );

    assign is_border           = head_data.is_border;
    assign neighbour_zone_mask = head_data.zone_mask;
    assign on_map_edge         = head_data.on_edge;
    assign last_tile           = head_data.last;

    // Back-to-back items on one column must see the value just written.
    a_bypass_same_column: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && $past(s1_valid_reg) && (s1_addr_reg == $past(s1_addr_reg)))
            |-> fwd_hit_reg)
        else $error("line buffer bypass missed for a repeated column");

    // Queued results plus the one in flight never exceed the queue.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_pending <= (RES_CNT_W+1)'(RES_DEPTH))
        else $error("result queue over-committed");

    // No item is taken while the line buffer sweep is running.
    a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !$past(clearing_reg))
        else $error("item accepted during the line buffer sweep");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the zone label border marker unit.
// ----------------------------------------------------------------------------
// A class tracks the line buffers, the 3x3 window and the tile counters, and
// works out the expected border, mask, edge and last-tile fields for every
// accepted item. Results are compared in order as they leave the block. The
// run starts with a few hand-picked maps, then random phases: each writes
// new register values and sends whole maps with flush items, or loose items.
// Both channels idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------

class border_scoreboard;

    localparam int unsigned LINE_LEN = 256;

    int unsigned width_reg;
    int unsigned height_reg;
    logic [63:0] wide_bits;

    logic [2:0] row_above [LINE_LEN];
    logic [2:0] row_here [LINE_LEN];
    logic [2:0] window [9];

    int unsigned next_col;
    int unsigned tiles_out;
    int unsigned items_taken;
    int unsigned out_x;
    int unsigned out_y;

    zlbm_pkg::result_t expected_marks [$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
        width_reg  = 72;
        height_reg = 72;
        wide_bits  = '0;
        foreach (row_above[i])
        begin
            row_above[i] = '0;
            row_here[i]  = '0;
        end
        foreach (window[i])
        begin
            window[i] = '0;
        end
        restart_map();
        errors       = 0;
        results_seen = 0;
    endfunction

    function void restart_map();
        next_col    = 0;
        tiles_out   = 0;
        items_taken = 0;
        out_x       = 0;
        out_y       = 0;
    endfunction

    // Register values outside 1..top act as the nearest bound.
    function int unsigned clamp_dim(int unsigned value, int unsigned top);
        if (value == 0)
        begin
            return 1;
        end
        return (value > top) ? top : value;
    endfunction

    function bit is_wide(logic [2:0] a, logic [2:0] b);
        return wide_bits[{a, b}] | wide_bits[{b, a}];
    endfunction

    function bit ring_tile(int x, int y, int w, int h);
        return (x == 0) || (y == 0) || (x == w - 1) || (y == h - 1);
    endfunction

    task report(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    function void set_reg(zlbm_pkg::cfg_index_t idx, logic [63:0] data);
        case (idx)
            zlbm_pkg::REG_MAP_WIDTH:  width_reg  = data[8:0];
            zlbm_pkg::REG_MAP_HEIGHT: height_reg = data[8:0];
            zlbm_pkg::REG_WIDE_PAIRS: wide_bits  = data;
            default: ;
        endcase
    endfunction

    function void note_tile(logic [2:0] lbl, logic fl);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int nx;
        int ny;
        logic [2:0] z;
        logic [2:0] centre;
        logic [2:0] nz;
        logic [7:0] mask;
        bit differ;
        bit wide;
        bit ring;
        zlbm_pkg::result_t mark;

        w = clamp_dim(width_reg, LINE_LEN);
        h = clamp_dim(height_reg, zlbm_pkg::HEIGHT_LIMIT);
        z = fl ? 3'd0 : lbl;

        if (next_col >= w)
        begin
            next_col = 0;
        end
        col = next_col;

        for (int r = 0; r < 3; r++)
        begin
            window[r * 3]     = window[r * 3 + 1];
            window[r * 3 + 1] = window[r * 3 + 2];
        end
        window[2]      = row_above[col];
        window[5]      = row_here[col];
        window[8]      = z;
        row_above[col] = row_here[col];
        row_here[col]  = z;

        next_col = (col + 1 >= w) ? 0 : col + 1;
        items_taken++;

        // The window is not yet centred on a tile of this map.
        if (items_taken < w + 1)
        begin
            return;
        end

        if (out_x >= w)
        begin
            out_x = 0;
            out_y++;
        end

        centre = window[4];
        ring   = ring_tile(out_x, out_y, w, h);
        differ = 1'b0;
        wide   = 1'b0;
        mask   = '0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                nx = int'(out_x) + dx;
                ny = int'(out_y) + dy;
                if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 &&
                    nx < int'(w) && ny < int'(h))
                begin
                    nz = window[(1 + dy) * 3 + 1 + dx];
                    if (nz != centre)
                    begin
                        differ = 1'b1;
                        if (is_wide(centre, nz))
                        begin
                            wide = 1'b1;
                        end
                        // Two ring tiles next to each other do not mark each other.
                        if (!ring || !ring_tile(nx, ny, w, h))
                        begin
                            mask[nz] = 1'b1;
                        end
                    end
                end
            end
        end

        mark.is_border = differ && !wide;
        mark.zone_mask = mask;
        mark.on_edge   = ring;
        mark.last      = (tiles_out + 1 >= w * h);
        expected_marks.push_back(mark);

        if (mark.last)
        begin
            restart_map();
        end
        else
        begin
            tiles_out++;
            out_x++;
        end
    endfunction

    task check_result(zlbm_pkg::result_t got);
        zlbm_pkg::result_t want;
        results_seen++;
        if (expected_marks.size() == 0)
        begin
            report("result arrived with no tile waiting for one");
            return;
        end
        want = expected_marks.pop_front();
        if (got.is_border !== want.is_border)
        begin
            report($sformatf("is_border got %b expected %b", got.is_border, want.is_border));
        end
        if (got.zone_mask !== want.zone_mask)
        begin
            report($sformatf("neighbour_zone_mask got %h expected %h",
                             got.zone_mask, want.zone_mask));
        end
        if (got.on_edge !== want.on_edge)
        begin
            report($sformatf("on_map_edge got %b expected %b", got.on_edge, want.on_edge));
        end
        if (got.last !== want.last)
        begin
            report($sformatf("last_tile got %b expected %b", got.last, want.last));
        end
    endtask

endclass

module tb_top;

    localparam int unsigned STALL_LIMIT = 4000;

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         cfg_wr_en    = 1'b0;
    zlbm_pkg::cfg_index_t         cfg_index    = zlbm_pkg::REG_MAP_WIDTH;
    logic [zlbm_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                         tile_valid   = 1'b0;
    logic                         tile_stall;
    logic [zlbm_pkg::LABEL_W-1:0] zone_label   = '0;
    logic                         flush        = 1'b0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic                         is_border;
    logic [zlbm_pkg::MASK_W-1:0]  neighbour_zone_mask;
    logic                         on_map_edge;
    logic                         last_tile;

    border_scoreboard sb = new();
    bit          idling = 1'b0;
    int unsigned rx_hold = 0;
    int unsigned quiet_cycles = 0;
    int unsigned tiles_sent = 0;

    zone_label_border_marker_unit u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .tile_valid          (tile_valid),
        .tile_stall          (tile_stall),
        .zone_label          (zone_label),
        .flush               (flush),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .is_border           (is_border),
        .neighbour_zone_mask (neighbour_zone_mask),
        .on_map_edge         (on_map_edge),
        .last_tile           (last_tile)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stalls come in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            result_stall <= 1'b1;
            rx_hold = rx_hold - 1;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            rx_hold = $urandom_range(0, 6);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Monitor and watchdog: values read here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                sb.check_result({is_border, neighbour_zone_mask, on_map_edge, last_tile});
            end
            if (tile_valid && !tile_stall)
            begin
                sb.note_tile(zone_label, flush);
            end
            if (cfg_wr_en)
            begin
                sb.set_reg(cfg_index, cfg_wr_data);
            end

            if ((result_valid && !result_stall) || (tile_valid && !tile_stall) || cfg_wr_en)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("** zone_label_border_marker_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [2:0] lbl, input logic fl);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            tile_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        tile_valid <= 1'b1;
        zone_label <= lbl;
        flush      <= fl;
        @(posedge clk);
        while (tile_stall) @(posedge clk);
        tiles_sent++;
    endtask

    // Stop sending, let every expected result out, then wait for the block to
    // finish an item that makes no result.
    task automatic drain();
        tile_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_marks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [8:0] w, input logic [8:0] h, input logic [63:0] m);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_wr_en   <= 1'b1;
        cfg_index   <= zlbm_pkg::REG_MAP_WIDTH;
        cfg_wr_data <= {junk[63:9], w};
        @(posedge clk);
        junk = {$urandom, $urandom};
        cfg_index   <= zlbm_pkg::REG_MAP_HEIGHT;
        cfg_wr_data <= {junk[63:9], h};
        @(posedge clk);
        cfg_index   <= zlbm_pkg::REG_WIDE_PAIRS;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One map in raster order from a small palette, then the flush items.
    task automatic run_map(input int unsigned w, input int unsigned h,
                           input int unsigned pal, input int unsigned base);
        repeat (w * h) send_item(3'(base + $urandom_range(0, pal - 1)), 1'b0);
        repeat (w + 1) send_item(3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial
    begin : stimulus
        logic [2:0] pattern [9] = '{3'd0, 3'd1, 3'd2, 3'd7, 3'd1, 3'd2, 3'd1, 3'd1, 3'd7};
        logic [8:0] wv;
        logic [8:0] hv;
        logic [63:0] mv;
        int unsigned w;
        int unsigned h;
        int unsigned phase;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (tile_stall) @(posedge clk);

        // 3x3 map with the pair 1,2 marked in one direction only.
        write_regs(9'd3, 9'd3, 64'h0000_0000_0000_0400);
        foreach (pattern[i])
        begin
            send_item(pattern[i], 1'b0);
        end
        repeat (4) send_item(3'd7, 1'b1);
        drain();

        // Zero width and height act as 1; every pair is wide. The second item
        // is a flush that stands in for a tile, and the third one follows a
        // finished map.
        write_regs(9'd0, 9'd0, '1);
        send_item(3'd7, 1'b0);
        send_item(3'd5, 1'b1);
        send_item(3'd3, 1'b0);
        send_item(3'd0, 1'b1);
        drain();
        write_regs(9'd1, 9'd2, '0);
        send_item(3'd7, 1'b0);
        send_item(3'd0, 1'b1);
        send_item(3'd6, 1'b1);
        send_item(3'd2, 1'b0);
        drain();

        for (phase = 0; tiles_sent < 800; phase++)
        begin
            idling = (tiles_sent < 600) && ($urandom_range(0, 3) != 0);
            case (phase)
                0:
                begin
                    wv = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
                    hv = 9'($urandom_range(0, 1));
                end
                1:
                begin
                    wv = 9'($urandom_range(0, 1));
                    hv = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
                end
                default:
                begin
                    wv = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 1))
                                                     : 9'($urandom_range(2, 12));
                    hv = 9'($urandom_range(0, 8));
                end
            endcase
            case ($urandom_range(0, 3))
                0: mv = '0;
                1: mv = '1;
                2:
                begin
                    mv = '0;
                    for (int a = 0; a < 8; a++)
                    begin
                        for (int b = a; b < 8; b++)
                        begin
                            if ($urandom_range(0, 3) == 0)
                            begin
                                mv[a * 8 + b] = 1'b1;
                                mv[b * 8 + a] = 1'b1;
                            end
                        end
                    end
                end
                default: mv = {$urandom, $urandom};
            endcase
            write_regs(wv, hv, mv);

            w = sb.clamp_dim(wv, 256);
            h = sb.clamp_dim(hv, zlbm_pkg::HEIGHT_LIMIT);
            if (phase < 2)
            begin
                run_map(w, h, $urandom_range(1, 8), $urandom_range(0, 7));
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                repeat ($urandom_range(1, 2))
                    run_map(w, h, $urandom_range(1, 8), $urandom_range(0, 7));
            end
            else
            begin
                // Loose items: partial maps, stray flushes, tiles past the end.
                repeat ($urandom_range(1, 3 * w + 3))
                    send_item(3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
            end
            drain();
        end

        idling = 1'b0;
        repeat (20) @(posedge clk);
        if (sb.expected_marks.size() != 0)
        begin
            sb.report($sformatf("%0d expected results never arrived",
                                sb.expected_marks.size()));
        end

        $display("Sent %0d tile items over %0d random register phases after the directed maps;",
                 tiles_sent, phase);
        $display("%0d results compared, %0d mismatches.", sb.results_seen, sb.errors);
        if (sb.errors == 0)
        begin
            $display("** zone_label_border_marker_unit: PASSED **");
        end
        else
        begin
            $display("** zone_label_border_marker_unit: FAILED **");
        end
        $finish;
    end

endmodule
